// ----- src/lz4d_pkg.sv -----
// ----------------------------------------------------------------------------
// LZ4 block decompressor package
// Shared payload types, operation codes and status codes.
// ----------------------------------------------------------------------------
package lz4d_pkg;

  localparam int unsigned LimitW = 17;

  // Operation codes carried in the input payload.
  localparam logic [1:0] OpFeed         = 2'd0;
  localparam logic [1:0] OpDrain        = 2'd1;
  localparam logic [1:0] OpRestartKeep  = 2'd2;
  localparam logic [1:0] OpRestartClear = 2'd3;

  // Status codes carried in the output payload.
  localparam logic [2:0] StOk        = 3'd0;
  localparam logic [2:0] StNeedInput = 3'd1;
  localparam logic [2:0] StMayFinish = 3'd2;
  localparam logic [2:0] StRefused   = 3'd3;
  localparam logic [2:0] StNoDrain   = 3'd4;
  localparam logic [2:0] StHalted    = 3'd5;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] status;
  } out_t;

endpackage

// ----- src/lz4d_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lz4d_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // A read of the address written in the same cycle returns the old data.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/lz4_block_decompressor.sv -----
// ----------------------------------------------------------------------------
// LZ4 block decompressor
// Resumable decoder that takes one operation per transaction and answers each
// with exactly one result.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid_i / in_stall_o / in_data_i) carries one
//   operation per transaction: feed a compressed byte, drain one match byte,
//   or restart with or without clearing the history. The output channel
//   (out_valid_o / out_stall_i / out_data_o) returns one result per input
//   transaction, in order: a decoded byte when out_valid is set, and a status.
//   The configuration channel writes the match window size; write it only
//   while no transaction is in flight. It is always ready.
//   An accepted input passes the RAM read stage and then the output register.
//   Throughput is one transaction per cycle, literals and drains alike, while
//   the receiver does not stall; the history ring is a single RAM with one
//   write and one read port; a drain reading the byte just pushed is forwarded.
//   When the receiver stalls, one result waits in the output register and one
//   in the RAM read stage; after that the input channel stalls as well.
//   Reset clears the decode state, the write pointer and the fill count and
//   sets the window to WINDOW_SIZE. The history RAM is not cleared; offsets
//   are checked against the fill count, so unwritten entries are never used.
// ----------------------------------------------------------------------------
module lz4_block_decompressor #(
  parameter int unsigned WINDOW_SIZE = 65536
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  lz4d_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lz4d_pkg::out_t                    out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lz4d_pkg::LimitW-1:0]       cfg_data_i
);

  localparam int unsigned AW = $clog2(WINDOW_SIZE);
  localparam int unsigned FW = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned LW = lz4d_pkg::LimitW;

  localparam logic [2:0] PhToken    = 3'd0;
  localparam logic [2:0] PhLitExt   = 3'd1;
  localparam logic [2:0] PhLiteral  = 3'd2;
  localparam logic [2:0] PhOffLo    = 3'd3;
  localparam logic [2:0] PhOffHi    = 3'd4;
  localparam logic [2:0] PhMatchExt = 3'd5;
  localparam logic [2:0] PhMatch    = 3'd6;

  localparam logic [31:0] CntMax = 32'hFFFF_FFFF;

  // Decode state.
  logic [2:0]    phase_q, phase_d;
  logic [31:0]   lit_rem_q, lit_rem_d;
  logic [31:0]   match_rem_q, match_rem_d;
  logic [15:0]   offset_q, offset_d;
  logic [AW-1:0] wp_q, wp_d;
  logic [FW-1:0] fill_q, fill_d;
  logic          halted_q, halted_d;
  logic [FW-1:0] limit_q;

  // RAM read stage.
  logic          s1_valid_q;
  logic          s1_wr_q;
  logic          s1_use_ram_q;
  logic [7:0]    s1_byte_q;
  logic [AW-1:0] s1_addr_q;
  logic [2:0]    s1_status_q;
  logic          s1_adv;
  logic [7:0]    s1_wdata;

  // Output register.
  logic           out_valid_q;
  lz4d_pkg::out_t out_data_q;

  logic          accept;
  logic          do_push;
  logic          drain_ok;
  logic [2:0]    status;
  logic [AW-1:0] rd_addr;
  logic [7:0]    ram_rdata;
  logic [FW-1:0] eff_fill;
  logic [15:0]   new_offset;
  logic          enter_match;
  logic [33:0]   match_sum;
  logic [32:0]   match_ext;
  logic [32:0]   lit_sum;
  logic [31:0]   match_total;
  logic [LW:0]   rd_lo;
  logic [LW:0]   rd_hi;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign s1_adv      = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !s1_adv;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // ---------------------------------------------------------------------------
  // Window configuration, clamped on write
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= FW'(WINDOW_SIZE);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_data_i == '0) begin
        limit_q <= FW'(1);
      end else if (cfg_data_i > LW'(WINDOW_SIZE)) begin
        limit_q <= FW'(WINDOW_SIZE);
      end else begin
        limit_q <= FW'(cfg_data_i);
      end
    end
  end

  assign eff_fill = (fill_q < limit_q) ? fill_q : limit_q;

  // Ring address of the byte a drain copies.
  assign rd_lo   = (LW + 1)'(wp_q) - (LW + 1)'(offset_q);
  assign rd_hi   = (LW + 1)'(wp_q) + (LW + 1)'(WINDOW_SIZE) - (LW + 1)'(offset_q);
  assign rd_addr = ((LW + 1)'(wp_q) >= (LW + 1)'(offset_q)) ? AW'(rd_lo) : AW'(rd_hi);

  assign new_offset  = {in_data_i.data_byte, offset_q[7:0]};
  assign lit_sum     = {1'b0, lit_rem_q} + 33'(in_data_i.data_byte);
  assign match_ext   = {1'b0, match_rem_q} + 33'(in_data_i.data_byte);
  assign match_sum   = {2'b00, match_rem_q} + 34'(in_data_i.data_byte) + 34'd4;

  // ---------------------------------------------------------------------------
  // Next-state logic for one accepted transaction
  // ---------------------------------------------------------------------------
  always_comb begin
    phase_d     = phase_q;
    lit_rem_d   = lit_rem_q;
    match_rem_d = match_rem_q;
    offset_d    = offset_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    halted_d    = halted_q;
    do_push     = 1'b0;
    drain_ok    = 1'b0;
    enter_match = 1'b0;
    match_total = match_rem_q;
    status      = lz4d_pkg::StOk;

    if (in_data_i.operation == lz4d_pkg::OpRestartKeep ||
        in_data_i.operation == lz4d_pkg::OpRestartClear) begin
      phase_d     = PhToken;
      lit_rem_d   = '0;
      match_rem_d = '0;
      offset_d    = '0;
      halted_d    = 1'b0;
      if (in_data_i.operation == lz4d_pkg::OpRestartClear) begin
        wp_d   = '0;
        fill_d = '0;
      end
    end else if (halted_q) begin
      status = lz4d_pkg::StHalted;
    end else if (in_data_i.operation == lz4d_pkg::OpDrain) begin
      if (phase_q != PhMatch) begin
        status = lz4d_pkg::StNoDrain;
      end else begin
        drain_ok    = 1'b1;
        do_push     = 1'b1;
        match_rem_d = match_rem_q - 32'd1;
        if (match_rem_q == 32'd1) begin
          phase_d = PhToken;
        end
      end
    end else if (phase_q == PhMatch) begin
      status = lz4d_pkg::StRefused;
    end else begin
      unique case (phase_q)
        PhToken: begin
          lit_rem_d   = 32'(in_data_i.data_byte[7:4]);
          match_rem_d = 32'(in_data_i.data_byte[3:0]);
          if (in_data_i.data_byte[7:4] == 4'd15) begin
            phase_d = PhLitExt;
          end else if (in_data_i.data_byte[7:4] != 4'd0) begin
            phase_d = PhLiteral;
          end else begin
            phase_d = PhOffLo;
          end
        end
        PhLitExt: begin
          lit_rem_d = lit_sum[32] ? CntMax : lit_sum[31:0];
          if (in_data_i.data_byte != 8'd255) begin
            phase_d = PhLiteral;
          end
        end
        PhLiteral: begin
          do_push   = 1'b1;
          lit_rem_d = lit_rem_q - 32'd1;
          if (lit_rem_q == 32'd1) begin
            phase_d = PhOffLo;
          end
        end
        PhOffLo: begin
          offset_d = {8'd0, in_data_i.data_byte};
          phase_d  = PhOffHi;
        end
        PhOffHi: begin
          offset_d = new_offset;
          if (match_rem_q == 32'd15) begin
            phase_d = PhMatchExt;
          end else begin
            enter_match = 1'b1;
            match_total = match_rem_q + 32'd4;
          end
        end
        PhMatchExt: begin
          if (in_data_i.data_byte != 8'd255) begin
            enter_match = 1'b1;
            match_total = (match_sum[33:32] != 2'b00) ? CntMax : match_sum[31:0];
          end else begin
            match_rem_d = match_ext[32] ? CntMax : match_ext[31:0];
          end
        end
        default: begin
          phase_d = PhToken;
        end
      endcase

      if (enter_match) begin
        match_rem_d = match_total;
        phase_d     = PhMatch;
        if (offset_d == 16'd0 || LW'(offset_d) > LW'(eff_fill)) begin
          halted_d = 1'b1;
        end
      end

      if (halted_d) begin
        status = lz4d_pkg::StHalted;
      end else if (phase_d == PhOffLo && match_rem_d == 32'd0) begin
        status = lz4d_pkg::StMayFinish;
      end else if (do_push || phase_d == PhMatch) begin
        status = lz4d_pkg::StOk;
      end else begin
        status = lz4d_pkg::StNeedInput;
      end
    end

    if (do_push) begin
      wp_d   = (wp_q == AW'(WINDOW_SIZE - 1)) ? '0 : wp_q + AW'(1);
      fill_d = (fill_q < limit_q) ? fill_q + FW'(1) : limit_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhToken;
      lit_rem_q   <= '0;
      match_rem_q <= '0;
      offset_q    <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      halted_q    <= 1'b0;
    end else if (accept) begin
      phase_q     <= phase_d;
      lit_rem_q   <= lit_rem_d;
      match_rem_q <= match_rem_d;
      offset_q    <= offset_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      halted_q    <= halted_d;
    end
  end

  // ---------------------------------------------------------------------------
  // History ring and read stage
  // ---------------------------------------------------------------------------
  // The byte a stage-one entry writes: a literal, a forwarded byte, or RAM data.
  assign s1_wdata = s1_use_ram_q ? ram_rdata : s1_byte_q;

  lz4d_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q && s1_wr_q && s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_wdata),
    .re_i    (accept && drain_ok),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // An empty stage one takes a transaction even while the output register is
  // stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv || !s1_valid_q) begin
      s1_valid_q <= accept;
    end
  end

  // The entry in stage one writes at the same edge as this read is taken, so
  // a drain that reads that address takes the byte from stage one instead.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_wr_q      <= do_push;
      s1_addr_q    <= wp_q;
      s1_status_q  <= status;
      if (drain_ok && s1_valid_q && s1_wr_q && s1_addr_q == rd_addr) begin
        s1_use_ram_q <= 1'b0;
        s1_byte_q    <= s1_wdata;
      end else begin
        s1_use_ram_q <= drain_ok;
        s1_byte_q    <= in_data_i.data_byte;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      out_data_q.out_byte  <= s1_wr_q ? s1_wdata : 8'd0;
      out_data_q.out_valid <= s1_wr_q;
      out_data_q.status    <= s1_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ----- test/lz4_block_decompressor_tb.sv -----
// ----------------------------------------------------------------------------
// LZ4 block decompressor testbench
// Sends a short table of hand-picked operations and then LZ4 sequences with
// random content, some with bad offsets or stray operations, under several
// match window sizes. The sender idles in bursts and the receiver stalls on
// its own pattern. A behavioral decoder predicts each result the table does
// not give, and each result is checked in order.
// ----------------------------------------------------------------------------
module lz4_block_decompressor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lz4d_pkg::*;

  localparam int unsigned WindowSize   = 65536;
  localparam int unsigned ScriptRows   = 27;
  localparam int unsigned PhaseCount   = 8;
  localparam int unsigned PhaseItems   = 140;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned QuietLimit   = 3000;
  localparam logic [31:0] MinMatch     = 32'd4;

  typedef enum logic [2:0] {
    PhToken, PhLitExt, PhLiteral, PhOffLo, PhOffHi, PhMatchExt, PhMatch
  } dec_phase_e;

  typedef struct {
    in_t  item;
    bit   typed;
    out_t want;
  } script_row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  in_t               in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  out_t              out_data_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [LimitW-1:0] cfg_data_i  = '0;

  // Behavioral decoder state, mirroring the block after reset.
  dec_phase_e        dec_phase  = PhToken;
  logic [31:0]       lit_left   = '0;
  logic [31:0]       match_left = '0;
  logic [15:0]       match_dist = '0;
  logic [7:0]        ring [WindowSize];
  logic [15:0]       ring_wr    = '0;
  logic [16:0]       ring_fill  = '0;
  logic [16:0]       win_limit  = 17'd65536;
  bit                dec_halted = 1'b0;

  out_t              pending_results [$];
  int unsigned       results_seen = 0;
  int unsigned       mismatches   = 0;
  int unsigned       items_sent   = 0;
  int unsigned       burst_left   = 0;
  int unsigned       gen_held     = 0;

  logic [16:0] phase_limits [PhaseCount] = '{
    17'd0, 17'd131071, 17'd2, 17'd65537, 17'd1, 17'd40, 17'd65536, 17'd300
  };

  script_row_t script [ScriptRows] = '{
    '{'{OpDrain,        8'h00}, 1'b1, '{8'h00, 1'b0, StNoDrain}},
    '{'{OpFeed,         8'h00}, 1'b1, '{8'h00, 1'b0, StMayFinish}},
    '{'{OpFeed,         8'h00}, 1'b1, '{8'h00, 1'b0, StNeedInput}},
    // An offset of zero halts the decoder.
    '{'{OpFeed,         8'h00}, 1'b1, '{8'h00, 1'b0, StHalted}},
    '{'{OpFeed,         8'hFF}, 1'b1, '{8'h00, 1'b0, StHalted}},
    '{'{OpDrain,        8'h5A}, 1'b1, '{8'h00, 1'b0, StHalted}},
    '{'{OpRestartClear, 8'hA5}, 1'b1, '{8'h00, 1'b0, StOk}},
    '{'{OpFeed,         8'h20}, 1'b1, '{8'h00, 1'b0, StNeedInput}},
    '{'{OpFeed,         8'hFF}, 1'b1, '{8'hFF, 1'b1, StOk}},
    '{'{OpFeed,         8'h00}, 1'b1, '{8'h00, 1'b1, StMayFinish}},
    '{'{OpFeed,         8'h02}, 1'b1, '{8'h00, 1'b0, StNeedInput}},
    '{'{OpFeed,         8'h00}, 1'b1, '{8'h00, 1'b0, StOk}},
    '{'{OpFeed,         8'h55}, 1'b1, '{8'h00, 1'b0, StRefused}},
    '{'{OpDrain,        8'h00}, 1'b0, '0},
    '{'{OpDrain,        8'hFF}, 1'b0, '0},
    '{'{OpDrain,        8'h00}, 1'b0, '0},
    '{'{OpDrain,        8'h00}, 1'b0, '0},
    // Offset one beyond the six bytes held.
    '{'{OpFeed,         8'h00}, 1'b0, '0},
    '{'{OpFeed,         8'h07}, 1'b0, '0},
    '{'{OpFeed,         8'h00}, 1'b0, '0},
    '{'{OpRestartKeep,  8'h3C}, 1'b1, '{8'h00, 1'b0, StOk}},
    // After a restart that keeps history, the oldest held byte is reachable.
    '{'{OpFeed,         8'h00}, 1'b0, '0},
    '{'{OpFeed,         8'h06}, 1'b0, '0},
    '{'{OpFeed,         8'h00}, 1'b0, '0},
    '{'{OpDrain,        8'hC3}, 1'b0, '0},
    '{'{OpDrain,        8'h00}, 1'b0, '0},
    '{'{OpDrain,        8'h81}, 1'b0, '0}
  };

  lz4_block_decompressor #(
    .WINDOW_SIZE(WindowSize)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- decoder

  function automatic logic [16:0] window_bytes();
    if (win_limit == '0) return 17'd1;
    if (win_limit > WindowSize) return 17'(WindowSize);
    return win_limit;
  endfunction

  function automatic logic [31:0] sat_sum(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic void ring_push(logic [7:0] b);
    logic [16:0] lim;
    lim = window_bytes();
    ring[ring_wr] = b;
    ring_wr = ring_wr + 16'd1;
    ring_fill = (ring_fill < lim) ? ring_fill + 17'd1 : lim;
  endfunction

  // The offset is judged when the match length is complete.
  function automatic void start_copy();
    logic [16:0] lim;
    logic [16:0] held;
    lim = window_bytes();
    held = (ring_fill < lim) ? ring_fill : lim;
    match_left = sat_sum(match_left, MinMatch);
    dec_phase = PhMatch;
    if (match_dist == '0 || {1'b0, match_dist} > held) dec_halted = 1'b1;
  endfunction

  function automatic out_t decode_step(in_t item);
    out_t        r;
    logic [7:0]  b;
    logic [15:0] src;
    r = '0;
    b = item.data_byte;
    if (item.operation == OpRestartKeep || item.operation == OpRestartClear) begin
      dec_phase = PhToken;
      lit_left = '0;
      match_left = '0;
      match_dist = '0;
      dec_halted = 1'b0;
      if (item.operation == OpRestartClear) begin
        ring_wr = '0;
        ring_fill = '0;
      end
      r.status = StOk;
    end else if (dec_halted) begin
      r.status = StHalted;
    end else if (item.operation == OpDrain) begin
      if (dec_phase != PhMatch) begin
        r.status = StNoDrain;
      end else begin
        src = ring_wr - match_dist;
        r.out_byte = ring[src];
        r.out_valid = 1'b1;
        ring_push(r.out_byte);
        match_left = match_left - 32'd1;
        if (match_left == '0) dec_phase = PhToken;
        r.status = StOk;
      end
    end else if (dec_phase == PhMatch) begin
      r.status = StRefused;
    end else begin
      case (dec_phase)
        PhToken: begin
          lit_left = {28'd0, b[7:4]};
          match_left = {28'd0, b[3:0]};
          if (b[7:4] == 4'hF) dec_phase = PhLitExt;
          else if (b[7:4] != 4'h0) dec_phase = PhLiteral;
          else dec_phase = PhOffLo;
        end
        PhLitExt: begin
          lit_left = sat_sum(lit_left, {24'd0, b});
          if (b != 8'hFF) dec_phase = PhLiteral;
        end
        PhLiteral: begin
          ring_push(b);
          r.out_byte = b;
          r.out_valid = 1'b1;
          lit_left = lit_left - 32'd1;
          if (lit_left == '0) dec_phase = PhOffLo;
        end
        PhOffLo: begin
          match_dist = {8'd0, b};
          dec_phase = PhOffHi;
        end
        PhOffHi: begin
          match_dist[15:8] = b;
          if (match_left == 32'd15) dec_phase = PhMatchExt;
          else start_copy();
        end
        PhMatchExt: begin
          match_left = sat_sum(match_left, {24'd0, b});
          if (b != 8'hFF) start_copy();
        end
        default: dec_phase = PhToken;
      endcase
      if (dec_halted) r.status = StHalted;
      else if (dec_phase == PhOffLo && match_left == '0) r.status = StMayFinish;
      else if (r.out_valid || dec_phase == PhMatch) r.status = StOk;
      else r.status = StNeedInput;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- sender

  function automatic in_t make_op(logic [1:0] op, logic [7:0] b);
    in_t r;
    r.operation = op;
    r.data_byte = b;
    return r;
  endfunction

  task automatic send(input in_t item, input bit typed = 1'b0, input out_t want = '0);
    out_t predicted;
    if (burst_left == 0) begin
      repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 48);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    predicted = decode_step(item);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    burst_left--;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  task automatic settle();
    if (burst_left != 0) in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LimitW-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    win_limit = value;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void note_emitted(logic [16:0] lim);
    gen_held = (gen_held < lim) ? gen_held + 1 : lim;
  endfunction

  task automatic send_restart();
    bit wipe;
    wipe = ($urandom_range(0, 2) == 0);
    send(make_op(wipe ? OpRestartClear : OpRestartKeep, 8'($urandom)));
    if (wipe) gen_held = 0;
  endtask

  // One LZ4 sequence with random content. A stretched sequence uses 255
  // extension bytes on both lengths.
  task automatic random_sequence(input bit stretch);
    int unsigned lit_nib, m_nib, lit_len, copy_len, ext, held, offs, pick;
    logic [16:0] lim;
    bit          ends_block, bad;
    lim = window_bytes();
    ends_block = !stretch && ($urandom_range(0, 99) < 10);
    pick = $urandom_range(0, 99);
    if (stretch || pick >= 85) lit_nib = 15;
    else if (pick < 50) lit_nib = $urandom_range(0, 3);
    else lit_nib = $urandom_range(4, 14);
    m_nib = ends_block ? 0 : (stretch ? 15 : $urandom_range(0, 15));
    send(make_op(OpFeed, {lit_nib[3:0], m_nib[3:0]}));
    lit_len = lit_nib;
    if (lit_nib == 15) begin
      do begin
        if (stretch && lit_len == 15) ext = 255;
        else ext = ($urandom_range(0, 49) == 0) ? 255 : $urandom_range(0, 12);
        send(make_op(OpFeed, ext[7:0]));
        lit_len += ext;
      end while (ext == 255);
    end
    repeat (lit_len) begin
      send(make_op(OpFeed, 8'($urandom)));
      note_emitted(lim);
    end
    // The last sequence of a block carries literals only.
    if (ends_block || $urandom_range(0, 99) < 3) begin
      send_restart();
      return;
    end
    held = (gen_held < lim) ? gen_held : lim;
    if (held > 65535) held = 65535;
    pick = $urandom_range(0, 99);
    if (held == 0 || pick < 8) begin
      if ($urandom_range(0, 1) == 0 || held == 65535) offs = 0;
      else offs = $urandom_range(held + 1, (held + 400 > 65535) ? 65535 : held + 400);
    end else if (pick < 20) begin
      offs = held;
    end else if (pick < 30) begin
      offs = 1;
    end else begin
      offs = $urandom_range(1, held);
    end
    bad = (offs == 0 || offs > held);
    send(make_op(OpFeed, offs[7:0]));
    send(make_op(OpFeed, offs[15:8]));
    copy_len = m_nib + 4;
    if (m_nib == 15) begin
      do begin
        if (stretch && copy_len == 19) ext = 255;
        else ext = ($urandom_range(0, 49) == 0) ? 255 : $urandom_range(0, 12);
        send(make_op(OpFeed, ext[7:0]));
        copy_len += ext;
      end while (ext == 255);
    end
    if (bad) begin
      repeat ($urandom_range(0, 3))
        send(make_op($urandom_range(0, 1) ? OpDrain : OpFeed, 8'($urandom)));
      send_restart();
      return;
    end
    repeat (copy_len) begin
      if ($urandom_range(0, 99) < 4) send(make_op(OpFeed, 8'($urandom)));
      send(make_op(OpDrain, 8'($urandom)));
      note_emitted(lim);
    end
    if ($urandom_range(0, 99) < 5) send(make_op(OpDrain, 8'($urandom)));
    if ($urandom_range(0, 99) < 4) send_restart();
  endtask

  initial begin : stimulus
    int unsigned p;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_limit(17'd65536);
    foreach (script[i]) send(script[i].item, script[i].typed, script[i].want);
    for (p = 0; p < PhaseCount; p++) begin
      settle();
      write_limit(phase_limits[p]);
      gen_held = ring_fill;
      if (p == 6) random_sequence(1'b1);
      while (items_sent < ScriptRows + (p + 1) * PhaseItems) random_sequence(1'b0);
    end
    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("lz4_block_decompressor: match");
    end else begin
      $display("lz4_block_decompressor: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------- receiver

  // Random stall modes, plus two long hold-offs so that the block backs up
  // into its input channel.
  initial begin : receiver
    int unsigned mode, span, k;
    bit          held_once, held_twice;
    held_once = 1'b0;
    held_twice = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 90);
      for (k = 0; k < span; k++) begin
        @(posedge clk_i);
        if ((!held_once && results_seen >= 250) || (!held_twice && results_seen >= 800)) begin
          if (held_once) held_twice = 1'b1;
          else held_once = 1'b1;
          out_stall_i <= 1'b1;
          repeat (HoldCycles) @(posedge clk_i);
        end
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 99) < 25);
          2: out_stall_i <= ($urandom_range(0, 99) < 75);
          default: out_stall_i <= (k % 4 == 3);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- checker

  function automatic void report_mismatch(string field, logic [7:0] want, logic [7:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("result %0d: %s expected %0h, got %0h", results_seen, field, want, got);
  endfunction

  always @(posedge clk_i) begin : check_results
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction, out_byte", 8'h00, out_data_o.out_byte);
      end else begin
        want = pending_results.pop_front();
        if (want.out_byte !== out_data_o.out_byte)
          report_mismatch("out_byte", want.out_byte, out_data_o.out_byte);
        if (want.out_valid !== out_data_o.out_valid)
          report_mismatch("out_valid", 8'(want.out_valid), 8'(out_data_o.out_valid));
        if (want.status !== out_data_o.status)
          report_mismatch("status", 8'(want.status), 8'(out_data_o.status));
      end
    end
  end

  // Ends the run when no transaction moves on any channel for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("lz4_block_decompressor: mismatch");
    $finish;
  end

endmodule
